>>> hw/rtl/srr_pkg.sv
// Shared types, codes and constants for the selective repeat receiver.
package srr_pkg;

  localparam int CFG_INDEX_W = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIZE    = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MESSAGE_LENGTH = 4'd1;

  localparam logic [5:0] WINDOW_SIZE_RESET = 6'd32;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_ACK  = 1'b1;

  typedef struct packed {
    logic        frame_valid;
    logic [31:0] frame_seq;
    logic [7:0]  frame_data;
  } srr_frame_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  out_byte;
    logic [31:0] ack_next_seq;
    logic [5:0]  ack_window;
    logic        message_complete;
    logic        last;
  } srr_result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_STORE,
    ST_READ,
    ST_EMIT,
    ST_ACK
  } srr_state_t;

  typedef struct packed {
    logic load_frame;
    logic calc;
    logic store;
    logic read;
    logic emit_byte;
    logic emit_ack;
  } srr_cmd_t;

  typedef struct packed {
    logic frame_ok;
    logic slot_full;
    logic out_free;
  } srr_status_t;

endpackage

>>> hw/rtl/srr_ram.sv
// Generic single write port RAM with one registered read port.
module srr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/srr_dp.sv
// Datapath: window check, reorder store, in-order drain and result register.
module srr_dp #(
  parameter int WINDOW_DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  srr_pkg::srr_cmd_t              cmd,
  output srr_pkg::srr_status_t           status,
  input  srr_pkg::srr_frame_t            rx_frame,
  input  logic                           cfg_write,
  input  logic [srr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output logic                           dl_valid,
  input  logic                           dl_ready,
  output srr_pkg::srr_result_t           dl_result
);
  import srr_pkg::*;

  localparam int IDX_W = $clog2(WINDOW_DEPTH);

  srr_frame_t               frame;
  logic [31:0]              seq_dist;
  logic [31:0]              span_hi;
  logic [31:0]              next_expected;
  logic [31:0]              recv_high_mark;
  logic [31:0]              delivered_count;
  logic [IDX_W-1:0]         ne_idx;
  logic [WINDOW_DEPTH-1:0]  slot_full;
  logic [5:0]               window_size;
  logic [31:0]              message_length;
  srr_result_t              out_r;
  logic                     out_valid;

  logic [5:0]               win;
  logic                     frame_ok;
  logic [IDX_W:0]           slot_sum;
  logic [IDX_W-1:0]         slot_idx;
  logic [31:0]              delivered_next;
  logic [31:0]              span_ack;
  logic [5:0]               free_win;
  logic [7:0]               rd_byte;
  logic                     out_free;

  // The window never exceeds the number of reorder slots.
  assign win = (32'(window_size) > 32'(WINDOW_DEPTH)) ? 6'(WINDOW_DEPTH) : window_size;
  assign frame_ok = frame.frame_valid && (seq_dist < {26'd0, win});

  // The frame lies within one depth of next_expected, so its slot follows
  // from the slot of next_expected by one add and one wrap.
  assign slot_sum = {1'b0, ne_idx} + {1'b0, seq_dist[IDX_W-1:0]};
  assign slot_idx = (slot_sum >= (IDX_W+1)'(WINDOW_DEPTH)) ?
                    IDX_W'(slot_sum - (IDX_W+1)'(WINDOW_DEPTH)) : IDX_W'(slot_sum);

  assign delivered_next = (delivered_count == 32'hFFFF_FFFF) ?
                          delivered_count : delivered_count + 32'd1;
  assign span_ack = recv_high_mark - next_expected;
  assign free_win = (span_ack > {26'd0, win}) ? 6'd0 : win - span_ack[5:0];
  assign out_free = !out_valid || dl_ready;

  assign status.frame_ok  = frame_ok;
  assign status.slot_full = slot_full[ne_idx];
  assign status.out_free  = out_free;

  assign dl_valid  = out_valid;
  assign dl_result = out_r;

  srr_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_slot_ram (
    .clk     (clk),
    .we      (cmd.store && frame_ok),
    .wr_addr (slot_idx),
    .wr_data (frame.frame_data),
    .re      (cmd.read),
    .rd_addr (ne_idx),
    .rd_data (rd_byte)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_frame) begin
      frame <= rx_frame;
    end
    if (cmd.calc) begin
      seq_dist <= frame.frame_seq - next_expected;
      span_hi  <= recv_high_mark - next_expected;
    end
    if (cmd.emit_byte) begin
      out_r.kind             <= KIND_DATA;
      out_r.out_byte         <= rd_byte;
      out_r.ack_next_seq     <= 32'd0;
      out_r.ack_window       <= 6'd0;
      out_r.message_complete <= (delivered_next >= message_length);
      out_r.last             <= 1'b0;
    end else if (cmd.emit_ack) begin
      out_r.kind             <= KIND_ACK;
      out_r.out_byte         <= 8'd0;
      out_r.ack_next_seq     <= next_expected;
      out_r.ack_window       <= free_win;
      out_r.message_complete <= (delivered_count >= message_length);
      out_r.last             <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_expected   <= 32'd0;
      recv_high_mark  <= 32'd0;
      delivered_count <= 32'd0;
      ne_idx          <= '0;
      slot_full       <= '0;
      window_size     <= WINDOW_SIZE_RESET;
      message_length  <= 32'd0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_WINDOW_SIZE:    window_size    <= cfg_data[5:0];
          REG_MESSAGE_LENGTH: message_length <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.store && frame_ok) begin
        slot_full[slot_idx] <= 1'b1;
        if (seq_dist >= span_hi) begin
          recv_high_mark <= frame.frame_seq + 32'd1;
        end
      end
      if (cmd.emit_byte) begin
        slot_full[ne_idx] <= 1'b0;
        next_expected     <= next_expected + 32'd1;
        delivered_count   <= delivered_next;
        ne_idx            <= (ne_idx == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : ne_idx + 1'b1;
      end
      if (cmd.emit_byte || cmd.emit_ack) begin
        out_valid <= 1'b1;
      end else if (dl_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_byte_from_full_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_byte |-> slot_full[ne_idx])
    else $error("byte released from an empty slot");

  a_store_marks_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.store && frame_ok) |=> slot_full[$past(slot_idx)])
    else $error("stored frame did not mark its slot");

  a_ack_is_last: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_ack |=> (out_valid && out_r.last && out_r.kind == KIND_ACK))
    else $error("acknowledgement not presented as the final beat");

endmodule

>>> hw/rtl/srr_ctrl.sv
// Controller state machine sequencing check, store, drain and acknowledgement.
module srr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rx_valid,
  output logic                  rx_ready,
  output srr_pkg::srr_cmd_t     cmd,
  input  srr_pkg::srr_status_t  status
);
  import srr_pkg::*;

  srr_state_t state;
  srr_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    rx_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        rx_ready = 1'b1;
        if (rx_valid) begin
          cmd.load_frame = 1'b1;
          state_next     = ST_DIST;
        end
      end
      ST_DIST: begin
        cmd.calc   = 1'b1;
        state_next = ST_STORE;
      end
      ST_STORE: begin
        cmd.store  = 1'b1;
        state_next = status.frame_ok ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        if (status.slot_full) begin
          cmd.read   = 1'b1;
          state_next = ST_EMIT;
        end else begin
          state_next = ST_ACK;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit_byte = 1'b1;
          state_next    = ST_READ;
        end
      end
      ST_ACK: begin
        if (status.out_free) begin
          cmd.emit_ack = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/selective_repeat_receiver.sv
// Top level of the selective repeat receiver: controller, datapath and ports.
// An accepted frame is loaded, then its sequence distance is computed, then it is stored.
// Each released byte is read from the slot RAM, then loaded into the result register; the
// acknowledgement is loaded last. Either load waits while the result register is still held.
// A rejected frame is dropped after the store state and produces no beat.
// Reset (synchronous, active high) clears sequence state, counters and all slot full bits at once.
module selective_repeat_receiver #(
  parameter int WINDOW_DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            rx_valid,
  output logic                            rx_ready,
  input  srr_pkg::srr_frame_t             rx_frame,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [srr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data,
  output logic                            dl_valid,
  input  logic                            dl_ready,
  output srr_pkg::srr_result_t            dl_result
);
  import srr_pkg::*;

  srr_cmd_t    cmd;
  srr_status_t status;

  // Registers are written only while the receiver is idle.
  assign cfg_ready = rx_ready && !rx_valid;

  srr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_ready (rx_ready),
    .cmd      (cmd),
    .status   (status)
  );

  srr_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .rx_frame  (rx_frame),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dl_valid  (dl_valid),
    .dl_ready  (dl_ready),
    .dl_result (dl_result)
  );

endmodule

>>> sim/tb_selective_repeat_receiver.sv
// Self-checking testbench for the selective repeat receiver: frames in, bytes and acks out.
`timescale 1ns / 1ps

module tb_selective_repeat_receiver;
  import srr_pkg::*;

  localparam int WIN_DEPTH     = 32;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_FRAMES = 160;
  localparam int PHASE_FRAMES  = 40;

  // Indexes that decode to no register.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 4'd15;

  class result_scoreboard;
    bit [5:0]    window_reg;
    bit [31:0]   length_reg;
    bit [31:0]   next_seq;
    bit [31:0]   high_mark;
    bit [31:0]   delivered;
    bit [7:0]    slot_byte [WIN_DEPTH];
    bit          slot_full [WIN_DEPTH];
    srr_result_t expected_q [$];
    int          errors;

    function new();
      window_reg = WINDOW_SIZE_RESET;
      length_reg = '0;
      next_seq   = '0;
      high_mark  = '0;
      delivered  = '0;
      errors     = 0;
      foreach (slot_full[i]) slot_full[i] = 1'b0;
    endfunction

    function int unsigned open_window();
      return (window_reg > WIN_DEPTH) ? WIN_DEPTH : window_reg;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task flag_mismatch(string msg);
      if (errors < 100) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    function void note_config(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_WINDOW_SIZE:    window_reg = data[5:0];
        REG_MESSAGE_LENGTH: length_reg = data;
        default: ;
      endcase
    endfunction

    function void push_result(logic kind, logic [7:0] b, logic [31:0] nseq, logic [5:0] w,
                              logic last);
      srr_result_t r;
      r.kind             = kind;
      r.out_byte         = b;
      r.ack_next_seq     = nseq;
      r.ack_window       = w;
      r.message_complete = (delivered >= length_reg);
      r.last             = last;
      expected_q.push_back(r);
    endfunction

    // Returns 1 when the frame lands in the window and so causes beats.
    function bit note_frame(srr_frame_t f);
      int unsigned win;
      int unsigned span;
      int unsigned idx;
      int unsigned drained;
      bit [31:0]   ahead;
      win   = open_window();
      ahead = f.frame_seq - next_seq;
      if (!f.frame_valid || ahead >= win) return 1'b0;
      if (ahead >= high_mark - next_seq) high_mark = f.frame_seq + 1;
      idx = f.frame_seq % WIN_DEPTH;
      slot_byte[idx] = f.frame_data;
      slot_full[idx] = 1'b1;
      drained = 0;
      while (drained < WIN_DEPTH && slot_full[next_seq % WIN_DEPTH]) begin
        idx = next_seq % WIN_DEPTH;
        slot_full[idx] = 1'b0;
        next_seq++;
        if (delivered != '1) delivered++;
        push_result(KIND_DATA, slot_byte[idx], '0, '0, 1'b0);
        drained++;
      end
      span = high_mark - next_seq;
      push_result(KIND_ACK, '0, next_seq, (span > win) ? 6'd0 : 6'(win - span), 1'b1);
      return 1'b1;
    endfunction

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) flag_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_result(srr_result_t got);
      srr_result_t want;
      if (expected_q.size() == 0) begin
        flag_mismatch($sformatf("beat with nothing expected: %h", got));
        return;
      end
      want = expected_q.pop_front();
      compare_field("kind", got.kind, want.kind);
      compare_field("out_byte", got.out_byte, want.out_byte);
      compare_field("ack_next_seq", got.ack_next_seq, want.ack_next_seq);
      compare_field("ack_window", got.ack_window, want.ack_window);
      compare_field("message_complete", got.message_complete, want.message_complete);
      compare_field("last", got.last, want.last);
    endtask
  endclass

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   rx_valid  = 1'b0;
  logic                   rx_ready;
  srr_frame_t             rx_frame  = '0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0]            cfg_data  = '0;
  logic                   dl_valid;
  logic                   dl_ready  = 1'b0;
  srr_result_t            dl_result;

  result_scoreboard sb;
  int useful_frames = 0;
  int results_seen  = 0;
  int hold_left     = 0;
  bit hold_req      = 1'b0;
  bit hold_done     = 1'b0;
  bit sender_calm   = 1'b0;

  selective_repeat_receiver #(.WINDOW_DEPTH(WIN_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_ready  (rx_ready),
    .rx_frame  (rx_frame),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dl_valid  (dl_valid),
    .dl_ready  (dl_ready),
    .dl_result (dl_result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  // Output side: random stalls, one long hold, and a calm stretch in the middle of the run.
  always @(posedge clk) begin
    if (!rst && dl_valid && dl_ready) begin
      sb.check_result(dl_result);
      results_seen <= results_seen + 1;
    end
    if (hold_left != 0) begin
      dl_ready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      dl_ready  <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else if (results_seen >= 120 && results_seen < 260) begin
      dl_ready <= 1'b1;
    end else begin
      dl_ready <= ($urandom_range(0, 99) >= 23);
    end
  end

  task automatic send_frame(input logic ok, input logic [31:0] seq, input logic [7:0] data);
    srr_frame_t f;
    f.frame_valid = ok;
    f.frame_seq   = seq;
    f.frame_data  = data;
    if (!sender_calm && $urandom_range(0, 99) < 23) begin
      rx_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_frame <= f;
    @(posedge clk);
    while (!rx_ready) @(posedge clk);
    if (sb.note_frame(f)) useful_frames++;
  endtask

  // Drains every expected beat, then lets a dropped frame still in flight clear the pipeline.
  task automatic quiesce();
    rx_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_config(idx, data);
  endtask

  task automatic reprogram(input logic [31:0] win_word, input logic [31:0] len_word,
                           input bit spare);
    quiesce();
    write_reg(REG_WINDOW_SIZE, win_word);
    write_reg(REG_MESSAGE_LENGTH, len_word);
    if (spare) begin
      write_reg(REG_SPARE_LO, $urandom());
      write_reg(REG_SPARE_HI, $urandom());
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned offs [$];
    int unsigned win;
    int unsigned k;
    int unsigned j;
    int unsigned tmp;
    int unsigned pick;
    int unsigned mode;
    bit [31:0]   base;
    bit [31:0]   win_word;
    bit [31:0]   len_word;
    bit          skip_zero;
    bit          need_cfg;
    int          phase;
    int          random_start;
    int          phase_start;

    sb = new();
    @(posedge clk);
    while (rst) @(posedge clk);

    // Reset settings: full window, message complete from the start.
    send_frame(1'b0, sb.next_seq, 8'hAA);
    send_frame(1'b1, sb.next_seq + 1, 8'hFF);
    send_frame(1'b1, sb.next_seq, 8'h00);
    send_frame(1'b1, sb.next_seq + 31, 8'h5A);
    send_frame(1'b1, sb.next_seq + 32, 8'h11);
    send_frame(1'b1, sb.next_seq + 31, 8'hA5);
    send_frame(1'b1, sb.next_seq - 1, 8'h33);
    send_frame(1'b1, 32'hFFFF_FFFF, 8'hC3);
    send_frame(1'b1, 32'h8000_0000, 8'h3C);

    // A zero window takes nothing; the upper data bits are not part of the register.
    reprogram({26'h3FF_FFFF, 6'd0}, sb.delivered + 2, 1'b1);
    send_frame(1'b1, sb.next_seq, 8'h01);

    // One-frame window, with the message completing on the second byte.
    reprogram(32'd1, sb.delivered + 2, 1'b0);
    send_frame(1'b1, sb.next_seq + 1, 8'h02);
    send_frame(1'b1, sb.next_seq, 8'h03);
    send_frame(1'b1, sb.next_seq, 8'h04);

    // A window above the slot count acts as the slot count.
    reprogram(32'd63, 32'hFFFF_FFFF, 1'b0);
    send_frame(1'b1, sb.next_seq + 20, 8'h81);
    send_frame(1'b1, sb.next_seq + 32, 8'h82);

    // Shrinking below the outstanding span advertises no free window.
    reprogram(32'd4, 32'd0, 1'b0);
    send_frame(1'b1, sb.next_seq + 1, 8'h83);
    send_frame(1'b1, sb.next_seq, 8'h84);

    random_start = useful_frames;
    phase_start  = useful_frames;
    phase        = 0;
    need_cfg     = 1'b1;
    while (useful_frames - random_start < RANDOM_FRAMES) begin
      if (useful_frames - phase_start >= PHASE_FRAMES) begin
        phase++;
        need_cfg = 1'b1;
      end
      if (need_cfg) begin
        pick     = $urandom_range(0, 9);
        win_word = $urandom();
        win_word[5:0] = (pick < 4) ? 6'($urandom_range(32, 63)) :
                        (pick < 8) ? 6'($urandom_range(2, 31)) : 6'($urandom_range(1, 3));
        case ($urandom_range(0, 3))
          0:       len_word = '0;
          1:       len_word = '1;
          2:       len_word = sb.delivered + $urandom_range(1, 60);
          default: len_word = $urandom();
        endcase
        reprogram(win_word, len_word, 1'b0);
        phase_start = useful_frames;
        need_cfg    = 1'b0;
        sender_calm = (phase == 1);
        if (phase == 2) hold_req <= 1'b1;
      end

      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // In-window run from the next expected frame: in order, reversed or shuffled.
        win  = sb.open_window();
        k    = $urandom_range(1, win);
        base = sb.next_seq;
        mode = $urandom_range(0, 3);
        offs.delete();
        for (int i = 0; i < k; i++) offs.push_back((mode == 0) ? k - 1 - i : i);
        if (mode >= 2) begin
          for (int i = k - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            tmp     = offs[i];
            offs[i] = offs[j];
            offs[j] = tmp;
          end
        end
        skip_zero = (k > 1 && $urandom_range(0, 4) == 0);
        foreach (offs[i]) begin
          if (!(skip_zero && offs[i] == 0)) send_frame(1'b1, base + offs[i], 8'($urandom()));
          if ($urandom_range(0, 7) == 0)
            send_frame(1'b1, base + offs[$urandom_range(0, i)], 8'($urandom()));
        end
      end else if (pick < 85) begin
        send_frame(1'b0, $urandom_range(0, 1) ? sb.next_seq + $urandom_range(0, 31) : $urandom(),
                   8'($urandom()));
      end else begin
        send_frame(1'b1, $urandom_range(0, 1) ?
                   sb.next_seq + sb.open_window() + $urandom_range(0, 999) : $urandom(),
                   8'($urandom()));
      end
    end

    quiesce();
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> selective_repeat_receiver.f
hw/rtl/srr_pkg.sv
hw/rtl/srr_ram.sv
hw/rtl/srr_dp.sv
hw/rtl/srr_ctrl.sv
hw/rtl/selective_repeat_receiver.sv
sim/tb_selective_repeat_receiver.sv
